>>> hdl/wildcard_byte_pattern_scanner_unit_macros.svh
// assertion macros for the wildcard byte pattern scanner
// expects clk and arst_n in the scope where a macro is used
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_UNIT_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define WBPS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scanner check failed");

// next-cycle implication, checked out of reset
`define WBPS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scanner check failed");

`endif

>>> hdl/wbps_pkg.sv
// shared types and constants of the wildcard byte pattern scanner
// no dependencies
`timescale 1ns / 1ps

package wbps_pkg;

	localparam int PATTERN_MAX_DEF = 32;
	localparam int PATTERN_STORE   = 32;
	localparam int KIDX_W          = $clog2(PATTERN_STORE);
	localparam int LEN_W           = $clog2(PATTERN_STORE + 1);
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 64;
	localparam int ADDR_W          = 64;
	localparam int OFFSET_W        = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LO    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_MID   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_UPPER = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_TOP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WILD_MASK = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd6;

	typedef struct packed {
		logic [7:0]        data_byte;
		logic              byte_mapped;
		logic [ADDR_W-1:0] byte_address;
		logic              end_of_range;
	} in_item_t;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] match_address;
	} out_item_t;

endpackage

>>> hdl/wbps_if.sv
// valid/ready channel interfaces for scanner bytes and results
// depends on wbps_pkg
`timescale 1ns / 1ps

interface wbps_in_if import wbps_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface wbps_out_if import wbps_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/wildcard_byte_pattern_scanner_unit.sv
// wildcard byte pattern scanner: window shift, masked compare, result register
// depends on wbps_pkg, wbps_if and the scanner assertion macros
`timescale 1ns / 1ps

// Takes one memory byte per cycle while the result side keeps up, and keeps a
// sliding window of the last PATTERN_MAX bytes with their mapped flags. A byte
// request enters the window register on acceptance; from there the window is
// compared against the pattern in all lanes at once and the 64-bit match
// address is formed, both landing in the result register once the result side
// is free. Bytes are pipelined: a new byte is accepted while the previous one
// moves on to the result register. One result per range: found=1 at the first
// match, or found=0 on the last byte of a range with no match. No clearing pass
// after reset. The user must write configuration only while idle; the block itself does not enforce it.

`include "wildcard_byte_pattern_scanner_unit_macros.svh"

module wildcard_byte_pattern_scanner_unit import wbps_pkg::*; #(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	wbps_in_if.sink               bytes,
	wbps_out_if.source            result
);

	localparam int LEN_LIM = (PATTERN_MAX < PATTERN_STORE) ? PATTERN_MAX : PATTERN_STORE;
	localparam int FILL_W  = $clog2(PATTERN_MAX + 1);

	// configuration
	logic [63:0]         pat_q [4];
	logic [31:0]         mask_q;
	logic [LEN_W-1:0]    plen_q;
	logic [OFFSET_W-1:0] offset_q;

	// window and stage one
	logic [7:0]             win_byte_q [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] win_map_q;
	logic [FILL_W-1:0]      fill_q;
	logic                   clear_q;
	logic                   valid_s1;
	logic [ADDR_W-1:0]      addr_s1;
	logic                   last_s1;

	// result stage
	logic      reported_q;
	logic      out_valid_q;
	out_item_t out_item_q;

	logic                    in_fire;
	logic                    s2_free;
	logic                    s1_adv;
	logic                    emit;
	logic [LEN_W-1:0]        len_eff;
	logic [LEN_W-1:0]        len_m1;
	logic [PATTERN_MAX-1:0]  lane_ok;
	logic [8*PATTERN_STORE-1:0] pattern_all;
	logic                    match;
	logic [ADDR_W-1:0]       match_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q[0] <= '0;
			pat_q[1] <= '0;
			pat_q[2] <= '0;
			pat_q[3] <= '0;
			mask_q   <= '0;
			plen_q   <= LEN_W'(1);
			offset_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_PAT_LO:    pat_q[0] <= cfg_data;
				REG_PAT_MID:   pat_q[1] <= cfg_data;
				REG_PAT_UPPER: pat_q[2] <= cfg_data;
				REG_PAT_TOP:   pat_q[3] <= cfg_data;
				REG_WILD_MASK: mask_q   <= cfg_data[31:0];
				REG_PAT_LEN:   plen_q   <= cfg_data[LEN_W-1:0];
				REG_OFFSET:    offset_q <= cfg_data[OFFSET_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign s2_free      = !out_valid_q || result.ready;
	assign s1_adv       = valid_s1 && s2_free;
	assign bytes.ready  = !valid_s1 || s2_free;
	assign in_fire      = bytes.valid && bytes.ready;

	// old window contents need no clearing, the fill count hides them
	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int e = 0; e < PATTERN_MAX - 1; e++) begin
				win_byte_q[e] <= win_byte_q[e+1];
				win_map_q[e]  <= win_map_q[e+1];
			end
			win_byte_q[PATTERN_MAX-1] <= bytes.payload.data_byte;
			win_map_q[PATTERN_MAX-1]  <= bytes.payload.byte_mapped;
			addr_s1                   <= bytes.payload.byte_address;
			last_s1                   <= bytes.payload.end_of_range;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			clear_q  <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
				clear_q  <= bytes.payload.end_of_range;
				if (clear_q) begin
					fill_q <= FILL_W'(1);
				end else if (fill_q != FILL_W'(PATTERN_MAX)) begin
					fill_q <= fill_q + 1'b1;
				end
			end else if (s2_free) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_comb begin
		if (plen_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (int'(plen_q) > LEN_LIM) begin
			len_eff = LEN_W'(LEN_LIM);
		end else begin
			len_eff = plen_q;
		end
	end

	assign len_m1      = len_eff - 1'b1;
	assign pattern_all = {pat_q[3], pat_q[2], pat_q[1], pat_q[0]};

	// lane e holds pattern byte e - (PATTERN_MAX - len) when that is not negative
	always_comb begin
		int               k;
		logic [KIDX_W-1:0] kidx;
		logic [7:0]       pb;
		for (int e = 0; e < PATTERN_MAX; e++) begin
			k    = e - (PATTERN_MAX - int'(len_eff));
			kidx = KIDX_W'(k);
			pb   = pattern_all[kidx*8 +: 8];
			lane_ok[e] = (k < 0) ||
				(win_map_q[e] && (mask_q[kidx] || win_byte_q[e] == pb));
		end
	end

	assign match      = (int'(fill_q) >= int'(len_eff)) && (&lane_ok);
	assign match_addr = addr_s1 - ADDR_W'(len_m1)
		+ {{(ADDR_W-OFFSET_W){offset_q[OFFSET_W-1]}}, offset_q};
	assign emit       = !reported_q && (match || last_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			reported_q  <= 1'b0;
		end else begin
			if (s1_adv && emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				if (last_s1) begin
					reported_q <= 1'b0;
				end else if (!reported_q && match) begin
					reported_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit) begin
			out_item_q.found         <= match;
			out_item_q.match_address <= match ? match_addr : '0;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.payload = out_item_q;

	// a no-match result carries a zero address
	`WBPS_ASSERT_NOW(a_nomatch_zero, out_valid_q && !out_item_q.found, out_item_q.match_address == '0)
	// a first match inside a range mutes the rest of that range
	`WBPS_ASSERT_NEXT(a_match_mutes, s1_adv && !reported_q && match && !last_s1, reported_q)
	// a stage one request held back by the result side stays put
	`WBPS_ASSERT_NEXT(a_s1_hold, valid_s1 && !s2_free, valid_s1 && $stable(addr_s1) && $stable(last_s1))

endmodule
